// File: rtl/core/iee_pkg.sv
// shared types, codes and helpers for the infix expression evaluator
`default_nettype none

package iee_pkg;

    typedef enum logic [2:0]
    {
        ACT_NUM   = 3'd0,
        ACT_OPEN  = 3'd1,
        ACT_CLOSE = 3'd2,
        ACT_ADD   = 3'd3,
        ACT_SUB   = 3'd4,
        ACT_MUL   = 3'd5,
        ACT_DIV   = 3'd6,
        ACT_END   = 3'd7
    } action_t;

    localparam logic [1:0] KIND_NUM   = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_OPERAND  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef enum logic [3:0]
    {
        CMD_NONE,
        CMD_LOAD,
        CMD_NUM,
        CMD_OPUSH,
        CMD_OPOP,
        CMD_READ_B,
        CMD_READ_A,
        CMD_APPLY,
        CMD_FINAL,
        CMD_FINISH
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DISPATCH,
        ST_NUM,
        ST_LOOK,
        ST_CHECK,
        ST_OPSTART,
        ST_RA,
        ST_WALU,
        ST_APPLY,
        ST_FINAL,
        ST_FIN
    } state_t;

    typedef struct packed
    {
        logic    pend_valid;
        logic    out_free;
        logic    op_empty;
        action_t op_top;
        logic    val_lt2;
        logic    alu_busy;
        action_t act;
    } status_t;

    function automatic logic [1:0] prec(input action_t code);
        logic [1:0] p;
        case (code) inside
            ACT_MUL, ACT_DIV: p = 2'd2;
            ACT_ADD, ACT_SUB: p = 2'd1;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/iee_ram.sv
// generic single write port ram with registered read
`default_nettype none

module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/iee_ctrl.sv
// controller state machine sequencing the evaluator datapath
`default_nettype none

module iee_ctrl
    import iee_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   can_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign can_emit = !st.pend_valid || st.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (st.act) inside
                    ACT_NUM:
                    begin
                        state_next = ST_NUM;
                    end
                    ACT_OPEN:
                    begin
                        cmd        = CMD_OPUSH;
                        state_next = ST_FIN;
                    end
                    default:
                    begin
                        state_next = ST_LOOK;
                    end
                endcase
            end
            ST_NUM:
            begin
                if (can_emit)
                begin
                    cmd        = CMD_NUM;
                    state_next = ST_FIN;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                case (st.act) inside
                    ACT_CLOSE:
                    begin
                        if (st.op_empty)
                        begin
                            state_next = ST_FIN;
                        end
                        else if (st.op_top == ACT_OPEN)
                        begin
                            cmd        = CMD_OPOP;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cmd        = CMD_OPOP;
                            state_next = ST_OPSTART;
                        end
                    end
                    ACT_END:
                    begin
                        if (st.op_empty)
                        begin
                            state_next = ST_FINAL;
                        end
                        else if (st.op_top == ACT_OPEN)
                        begin
                            cmd        = CMD_OPOP;
                            state_next = ST_LOOK;
                        end
                        else
                        begin
                            cmd        = CMD_OPOP;
                            state_next = ST_OPSTART;
                        end
                    end
                    default:
                    begin
                        if (!st.op_empty && (prec(st.act) <= prec(st.op_top)))
                        begin
                            cmd        = CMD_OPOP;
                            state_next = ST_OPSTART;
                        end
                        else
                        begin
                            cmd        = CMD_OPUSH;
                            state_next = ST_FIN;
                        end
                    end
                endcase
            end
            ST_OPSTART:
            begin
                if (st.val_lt2)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd        = CMD_READ_B;
                    state_next = ST_RA;
                end
            end
            ST_RA:
            begin
                cmd        = CMD_READ_A;
                state_next = ST_WALU;
            end
            ST_WALU:
            begin
                if (!st.alu_busy)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (can_emit)
                begin
                    cmd        = CMD_APPLY;
                    state_next = ST_LOOK;
                end
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    cmd        = CMD_FINAL;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (can_emit)
                begin
                    cmd        = CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/iee_datapath.sv
// stacks, serial multiply and divide unit, result staging and output register
`default_nettype none

module iee_datapath
    import iee_pkg::*;
#(
    parameter int OPERATOR_DEPTH = 16,
    parameter int VALUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 st,
    input  wire logic        [2:0]  action,
    input  wire logic signed [31:0] token_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [1:0]  out_kind,
    output logic             [1:0]  out_operator,
    output logic signed      [31:0] out_value,
    output logic             [1:0]  error_code,
    output logic                    last
);

    localparam int OA_W = $clog2(OPERATOR_DEPTH);
    localparam int OC_W = $clog2(OPERATOR_DEPTH + 1);
    localparam int VA_W = $clog2(VALUE_DEPTH);
    localparam int VC_W = $clog2(VALUE_DEPTH + 1);
    localparam int VW   = VALUE_WIDTH;
    localparam int CN_W = $clog2(VALUE_WIDTH + 1);

    // control state
    logic [OC_W-1:0] oc_reg, oc_next;
    logic [VC_W-1:0] vc_reg, vc_next;
    logic [1:0]      err_reg, err_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            busy_reg, busy_next;
    logic [CN_W-1:0] cnt_reg, cnt_next;

    // payload
    action_t         act_reg;
    logic [VW-1:0]   tok_reg;
    action_t         cur_op_reg;
    logic [VW-1:0]   a_reg, b_reg;
    logic [VW-1:0]   acc_reg, acc_next;
    logic [VW-1:0]   mc_reg, mc_next;
    logic [VW-1:0]   mp_reg, mp_next;
    logic [VW:0]     rem_reg, rem_next;
    logic [VW-1:0]   dvs_reg, dvs_next;
    logic            neg_reg, neg_next;
    logic [1:0]      pend_kind_reg, pend_op_reg, pend_err_reg;
    logic [31:0]     pend_value_reg;
    logic [1:0]      out_kind_reg, out_op_reg, out_err_reg;
    logic [31:0]     out_value_reg;
    logic            out_last_reg;

    // stack memories
    logic            op_we;
    logic [OA_W-1:0] op_waddr, op_raddr;
    logic [2:0]      op_rdata;
    logic            val_we;
    logic [VA_W-1:0] val_waddr, val_raddr;
    logic [VW-1:0]   val_wdata, val_rdata;

    logic [OC_W-1:0] oc_m1;
    logic [VC_W-1:0] vc_m1, vc_m2;
    logic [63:0]     tok_ext, fin_ext, val_ext;
    logic [VW-1:0]   fin_val, op_res, abs_a, abs_b;
    logic [VW:0]     rem_sh;
    logic            op_div_zero;
    logic            emit;
    logic [1:0]      new_kind, new_op, new_err;
    logic [31:0]     new_value;

    assign oc_m1    = oc_reg - OC_W'(1);
    assign vc_m1    = vc_reg - VC_W'(1);
    assign vc_m2    = vc_reg - VC_W'(2);
    assign op_raddr = oc_m1[OA_W-1:0];
    assign val_raddr = (cmd == CMD_READ_B) ? vc_m2[VA_W-1:0] : vc_m1[VA_W-1:0];

    iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_op_ram (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (act_reg),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    iee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(VALUE_DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign tok_ext  = 64'(token_value);
    assign fin_val  = (vc_reg != '0) ? val_rdata : '0;
    assign fin_ext  = 64'(signed'(fin_val));
    assign val_ext  = 64'(signed'(tok_reg));
    assign abs_a    = val_rdata[VW-1] ? (VW'(0) - val_rdata) : val_rdata;
    assign abs_b    = b_reg[VW-1] ? (VW'(0) - b_reg) : b_reg;
    assign rem_sh   = {rem_reg[VW-1:0], mp_reg[VW-1]};
    assign op_div_zero = (b_reg == '0);

    always_comb
    begin
        case (cur_op_reg) inside
            ACT_ADD: op_res = a_reg + b_reg;
            ACT_SUB: op_res = a_reg - b_reg;
            ACT_MUL: op_res = acc_reg;
            default: op_res = op_div_zero ? '0 : (neg_reg ? (VW'(0) - mp_reg) : mp_reg);
        endcase
    end

    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = !out_valid_reg;
    assign st.op_empty   = (oc_reg == '0);
    assign st.op_top     = action_t'(op_rdata);
    assign st.val_lt2    = (vc_reg < VC_W'(2));
    assign st.alu_busy   = busy_reg;
    assign st.act        = act_reg;

    always_comb
    begin
        oc_next         = oc_reg;
        vc_next         = vc_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        busy_next       = busy_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mc_next         = mc_reg;
        mp_next         = mp_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        op_we           = 1'b0;
        op_waddr        = oc_reg[OA_W-1:0];
        val_we          = 1'b0;
        val_waddr       = vc_reg[VA_W-1:0];
        val_wdata       = tok_reg;
        emit            = 1'b0;
        new_kind        = KIND_NUM;
        new_op          = 2'd0;
        new_value       = '0;
        new_err         = ERR_NONE;

        if (busy_reg)
        begin
            if (cur_op_reg == ACT_MUL)
            begin
                if (mp_reg[0])
                begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = mc_reg << 1;
                mp_next = mp_reg >> 1;
            end
            else
            begin
                mp_next = {mp_reg[VW-2:0], 1'b0};
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_next   = rem_sh - {1'b0, dvs_reg};
                    mp_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = rem_sh;
                end
            end
            cnt_next = cnt_reg - CN_W'(1);
            if (cnt_reg == CN_W'(1))
            begin
                busy_next = 1'b0;
            end
        end

        case (cmd)
            CMD_NUM:
            begin
                if (vc_reg < VC_W'(VALUE_DEPTH))
                begin
                    val_we  = 1'b1;
                    vc_next = vc_reg + VC_W'(1);
                end
                else if (err_reg == ERR_NONE)
                begin
                    err_next = ERR_OVERFLOW;
                end
                emit      = 1'b1;
                new_kind  = KIND_NUM;
                new_value = val_ext[31:0];
            end
            CMD_OPUSH:
            begin
                if (oc_reg < OC_W'(OPERATOR_DEPTH))
                begin
                    op_we   = 1'b1;
                    oc_next = oc_reg + OC_W'(1);
                end
                else if (err_reg == ERR_NONE)
                begin
                    err_next = ERR_OVERFLOW;
                end
            end
            CMD_OPOP:
            begin
                oc_next = oc_m1;
            end
            CMD_READ_A:
            begin
                if (cur_op_reg == ACT_MUL)
                begin
                    busy_next = 1'b1;
                    cnt_next  = CN_W'(VW);
                    acc_next  = '0;
                    mc_next   = val_rdata;
                    mp_next   = b_reg;
                end
                else if (cur_op_reg == ACT_DIV && b_reg != '0)
                begin
                    busy_next = 1'b1;
                    cnt_next  = CN_W'(VW);
                    rem_next  = '0;
                    mp_next   = abs_a;
                    dvs_next  = abs_b;
                    neg_next  = val_rdata[VW-1] ^ b_reg[VW-1];
                end
            end
            CMD_APPLY:
            begin
                if (vc_reg < VC_W'(2))
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_OPERAND;
                    end
                end
                else
                begin
                    if (cur_op_reg == ACT_DIV && op_div_zero && err_reg == ERR_NONE)
                    begin
                        err_next = ERR_DIV_ZERO;
                    end
                    val_we    = 1'b1;
                    val_waddr = vc_m2[VA_W-1:0];
                    val_wdata = op_res;
                    vc_next   = vc_m1;
                end
                emit     = 1'b1;
                new_kind = KIND_OP;
                new_op   = 2'(cur_op_reg - ACT_ADD);
            end
            CMD_FINAL:
            begin
                if (vc_reg == '0 && err_reg == ERR_NONE)
                begin
                    new_err = ERR_OPERAND;
                end
                else
                begin
                    new_err = err_reg;
                end
                // stacks and error clear once the final value is staged
                oc_next   = '0;
                vc_next   = '0;
                err_next  = ERR_NONE;
                emit      = 1'b1;
                new_kind  = KIND_FINAL;
                new_value = fin_ext[31:0];
            end
            CMD_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (cmd != CMD_FINAL)
        begin
            new_err = err_next;
        end

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
            end
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg         <= '0;
            vc_reg         <= '0;
            err_reg        <= ERR_NONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            oc_reg         <= oc_next;
            vc_reg         <= vc_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            busy_reg       <= busy_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        if (cmd == CMD_LOAD)
        begin
            act_reg <= action_t'(action);
            tok_reg <= tok_ext[VW-1:0];
        end
        if (cmd == CMD_OPOP)
        begin
            cur_op_reg <= action_t'(op_rdata);
        end
        if (cmd == CMD_READ_B)
        begin
            b_reg <= val_rdata;
        end
        if (cmd == CMD_READ_A)
        begin
            a_reg <= val_rdata;
        end
        if ((emit || cmd == CMD_FINISH) && pend_valid_reg)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_op_reg    <= pend_op_reg;
            out_value_reg <= pend_value_reg;
            out_err_reg   <= pend_err_reg;
            out_last_reg  <= (cmd == CMD_FINISH);
        end
        if (emit)
        begin
            pend_kind_reg  <= new_kind;
            pend_op_reg    <= new_op;
            pend_value_reg <= new_value;
            pend_err_reg   <= new_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_operator = out_op_reg;
    assign out_value    = out_value_reg;
    assign error_code   = out_err_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/infix_expression_evaluator.sv
// infix expression evaluator: shunting-yard with immediate postfix evaluation
// one item accepted when idle; a popped operator with a missing operand skips the
// operand reads, multiply and divide run in the bit-serial unit; a full output stalls
// results leave through a one-deep staging register and an output register
// asynchronous active-low reset empties both stacks and clears the error
`default_nettype none

module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int OPERATOR_DEPTH = 16,
    parameter int VALUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [2:0]  action,
    input  wire logic signed [31:0] token_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [1:0]  out_kind,
    output logic             [1:0]  out_operator,
    output logic signed      [31:0] out_value,
    output logic             [1:0]  error_code,
    output logic                    last
);

    cmd_t    cmd;
    status_t st;

    iee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    iee_datapath #(
        .OPERATOR_DEPTH (OPERATOR_DEPTH),
        .VALUE_DEPTH    (VALUE_DEPTH),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .action       (action),
        .token_value  (token_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_operator (out_operator),
        .out_value    (out_value),
        .error_code   (error_code),
        .last         (last)
    );

endmodule

`default_nettype wire
